// ----- rtl/cbt_pkg.sv -----
// cbt_pkg: shared types, constants and helpers of the c-like byte tokenizer
// no dependencies; used by cbt_out_if, cbt_scan, cbt_obuf and the top level
`default_nettype none

package cbt_pkg;

  // default widths of the counters and the integer value
  localparam int unsigned LINE_BITS_DEF   = 20;
  localparam int unsigned OFFSET_BITS_DEF = 32;
  localparam int unsigned VALUE_BITS_DEF  = 32;

  // token length field, fixed
  localparam int unsigned LEN_BITS = 16;
  localparam int unsigned KIND_BITS = 5;

  // bytes of an identifier kept for keyword matching
  localparam int unsigned KW_BYTES = 5;

  // control characters
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // keyword text, first byte in the low bits, unused bytes zero
  localparam logic [8*KW_BYTES-1:0] KW_ELSE  = 40'h00_65_73_6C_65;
  localparam logic [8*KW_BYTES-1:0] KW_FALSE = 40'h65_73_6C_61_66;
  localparam logic [8*KW_BYTES-1:0] KW_IF    = 40'h00_00_00_66_69;
  localparam logic [8*KW_BYTES-1:0] KW_TRUE  = 40'h00_65_75_72_74;
  localparam logic [8*KW_BYTES-1:0] KW_WHILE = 40'h65_6C_69_68_77;

  typedef enum logic [KIND_BITS-1:0] {
    TK_EOF     = 5'd0,
    TK_IDENT   = 5'd1,
    TK_INT     = 5'd2,
    TK_ELSE    = 5'd3,
    TK_FALSE   = 5'd4,
    TK_IF      = 5'd5,
    TK_TRUE    = 5'd6,
    TK_WHILE   = 5'd7,
    TK_SEMI    = 5'd8,
    TK_LPAREN  = 5'd9,
    TK_RPAREN  = 5'd10,
    TK_LBRACE  = 5'd11,
    TK_RBRACE  = 5'd12,
    TK_ASSIGN  = 5'd13,
    TK_MINUS   = 5'd14,
    TK_PLUS    = 5'd15,
    TK_STAR    = 5'd16,
    TK_SLASH   = 5'd17,
    TK_PERCENT = 5'd18,
    TK_LT      = 5'd19,
    TK_LE      = 5'd20,
    TK_GT      = 5'd21,
    TK_GE      = 5'd22,
    TK_EQ      = 5'd23,
    TK_NE      = 5'd24,
    TK_NOT     = 5'd25,
    TK_ERROR   = 5'd26
  } tok_kind_e;

  // beats pushed by the scanner into the result queue
  typedef struct packed {
    logic [1:0] count;
  } cbt_push_t;

  // result queue slots free after this cycle's pop
  typedef struct packed {
    logic [1:0] free;
  } cbt_room_t;

  // width of one packed token: kind, line, start, length, value, overflow, last
  function automatic int unsigned tok_width(int unsigned lb, int unsigned ob, int unsigned vb);
    return KIND_BITS + lb + ob + LEN_BITS + vb + 2;
  endfunction

  // operator kind of a byte; with_eq selects the two-character form
  function automatic tok_kind_e op_kind(logic [7:0] c, logic with_eq);
    tok_kind_e k;
    case (c)
      ";":     k = TK_SEMI;
      "(":     k = TK_LPAREN;
      ")":     k = TK_RPAREN;
      "{":     k = TK_LBRACE;
      "}":     k = TK_RBRACE;
      "=":     k = with_eq ? TK_EQ : TK_ASSIGN;
      "-":     k = TK_MINUS;
      "+":     k = TK_PLUS;
      "*":     k = TK_STAR;
      "/":     k = TK_SLASH;
      "%":     k = TK_PERCENT;
      "<":     k = with_eq ? TK_LE : TK_LT;
      ">":     k = with_eq ? TK_GE : TK_GT;
      "!":     k = with_eq ? TK_NE : TK_NOT;
      default: k = TK_ERROR;
    endcase
    return k;
  endfunction

  // keyword match on the buffered prefix and the length
  function automatic tok_kind_e ident_kind(logic [8*KW_BYTES-1:0] kw, logic [LEN_BITS-1:0] len);
    tok_kind_e k;
    k = TK_IDENT;
    if (len == LEN_BITS'(4) && kw == KW_ELSE) k = TK_ELSE;
    else if (len == LEN_BITS'(5) && kw == KW_FALSE) k = TK_FALSE;
    else if (len == LEN_BITS'(2) && kw == KW_IF) k = TK_IF;
    else if (len == LEN_BITS'(4) && kw == KW_TRUE) k = TK_TRUE;
    else if (len == LEN_BITS'(5) && kw == KW_WHILE) k = TK_WHILE;
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cbt_in_if.sv -----
// cbt_in_if: input channel of the tokenizer, one source byte or end per beat
// depends on nothing
`default_nettype none

interface cbt_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_byte;

  modport source (output valid, kind, char_byte, input ready);
  modport sink   (input valid, kind, char_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/cbt_out_if.sv -----
// cbt_out_if: result channel of the tokenizer, one token per beat
// depends on cbt_pkg for default widths
`default_nettype none

interface cbt_out_if #(
  parameter int unsigned LINE_BITS   = cbt_pkg::LINE_BITS_DEF,
  parameter int unsigned OFFSET_BITS = cbt_pkg::OFFSET_BITS_DEF,
  parameter int unsigned VALUE_BITS  = cbt_pkg::VALUE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [4:0]             token_kind;
  logic [LINE_BITS-1:0]   line_number;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [15:0]            token_length;
  logic [VALUE_BITS-1:0]  int_value;
  logic                   int_overflow;
  logic                   last_of_run;

  modport source (output valid, token_kind, line_number, start_offset, token_length,
                  int_value, int_overflow, last_of_run, input ready);
  modport sink   (input valid, token_kind, line_number, start_offset, token_length,
                  int_value, int_overflow, last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/c_like_byte_tokenizer.sv -----
// c_like_byte_tokenizer: streaming lexer for a small c-like language
// depends on cbt_pkg, cbt_in_if, cbt_out_if, cbt_scan and cbt_obuf
// a beat taken goes into the input register and is scanned from there; its
//   first token is written into the result queue, whose head drives token_o
// throughput: one input beat per cycle while the result queue has room; a beat
//   that makes two tokens fills both queue slots, drained by the single output port
// reset: rst_ni clears all scanner state at once (line count to one), no sweep
`default_nettype none

module c_like_byte_tokenizer #(
  parameter int unsigned LINE_BITS   = cbt_pkg::LINE_BITS_DEF,
  parameter int unsigned OFFSET_BITS = cbt_pkg::OFFSET_BITS_DEF,
  parameter int unsigned VALUE_BITS  = cbt_pkg::VALUE_BITS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  cbt_in_if.sink     byte_i,
  cbt_out_if.source  token_o
);
  import cbt_pkg::*;

  // packed token layout, low to high: last, overflow, value, length, start, line, kind
  localparam int unsigned TOK_W    = tok_width(LINE_BITS, OFFSET_BITS, VALUE_BITS);
  localparam int unsigned VAL_LO   = 2;
  localparam int unsigned LEN_LO   = VAL_LO + VALUE_BITS;
  localparam int unsigned START_LO = LEN_LO + LEN_BITS;
  localparam int unsigned LINE_LO  = START_LO + OFFSET_BITS;
  localparam int unsigned KIND_LO  = LINE_LO + LINE_BITS;

  cbt_push_t        push;
  cbt_room_t        room;
  logic [TOK_W-1:0] tok0, tok1, head;

  // scanner: input register plus all lexer state; fires when the queue has room
  // for every token this beat makes
  cbt_scan #(
    .LINE_BITS  (LINE_BITS),
    .OFFSET_BITS(OFFSET_BITS),
    .VALUE_BITS (VALUE_BITS),
    .TOK_W      (TOK_W)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_i),
    .room_i (room),
    .push_o (push),
    .tok0_o (tok0),
    .tok1_o (tok1)
  );

  // result register: two slots so a flushed token and its follower leave in order
  cbt_obuf #(
    .WIDTH(TOK_W)
  ) u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok0_i  (tok0),
    .tok1_i  (tok1),
    .room_o  (room),
    .valid_o (token_o.valid),
    .ready_i (token_o.ready),
    .data_o  (head)
  );

  // unpack the head of the queue onto the output beat
  assign token_o.token_kind   = head[KIND_LO +: KIND_BITS];
  assign token_o.line_number  = head[LINE_LO +: LINE_BITS];
  assign token_o.start_offset = head[START_LO +: OFFSET_BITS];
  assign token_o.token_length = head[LEN_LO +: LEN_BITS];
  assign token_o.int_value    = head[VAL_LO +: VALUE_BITS];
  assign token_o.int_overflow = head[1];
  assign token_o.last_of_run  = head[0];

endmodule

`default_nettype wire

// ----- rtl/cbt_scan.sv -----
// cbt_scan: input register, scanner state and token formation, up to two tokens a beat
// depends on cbt_pkg and cbt_in_if
`default_nettype none

module cbt_scan #(
  parameter int unsigned LINE_BITS   = cbt_pkg::LINE_BITS_DEF,
  parameter int unsigned OFFSET_BITS = cbt_pkg::OFFSET_BITS_DEF,
  parameter int unsigned VALUE_BITS  = cbt_pkg::VALUE_BITS_DEF,
  parameter int unsigned TOK_W       = cbt_pkg::tok_width(LINE_BITS, OFFSET_BITS, VALUE_BITS)
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  cbt_in_if.sink                 byte_i,
  input  cbt_pkg::cbt_room_t     room_i,
  output cbt_pkg::cbt_push_t     push_o,
  output logic [TOK_W-1:0]       tok0_o,
  output logic [TOK_W-1:0]       tok1_o
);
  import cbt_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_INT, M_OP, M_SLASH, M_COMMENT, M_HALT
  } mode_e;

  typedef enum logic [1:0] {
    PAIR_NONE, PAIR_CR, PAIR_LF
  } pair_e;

  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  // input register
  logic       iv_q;
  logic       ikind_q;
  logic [7:0] ichar_q;

  // scanner state
  mode_e                    mode_q, mode_d;
  pair_e                    pair_q, pair_d;
  logic [7:0]               pend_q, pend_d;
  logic [8*KW_BYTES-1:0]    kw_q, kw_d;
  logic [LEN_BITS-1:0]      len_q, len_d;
  logic [OFFSET_BITS-1:0]   start_q, start_d;
  logic [OFFSET_BITS-1:0]   pos_q, pos_d;
  logic [LINE_BITS-1:0]     line_q, line_d;
  logic [VALUE_BITS-1:0]    val_q, val_d;
  logic                     ovf_q, ovf_d;

  // token formation
  logic                     has_f, has_n, cont, nl, fire;
  tok_kind_e                f_kind, n_kind;
  logic [LEN_BITS-1:0]      f_len, n_len;
  logic [OFFSET_BITS-1:0]   n_start;
  logic [VALUE_BITS-1:0]    f_val;
  logic                     f_ovf;
  logic [VALUE_BITS+3:0]    prod;
  logic [1:0]               cnt;
  pair_e                    mine;
  logic [TOK_W-1:0]         f_tok, n_tok;

  always_comb begin
    mode_d  = mode_q;
    pair_d  = pair_q;
    pend_d  = pend_q;
    kw_d    = kw_q;
    len_d   = len_q;
    start_d = start_q;
    pos_d   = pos_q;
    line_d  = line_q;
    val_d   = val_q;
    ovf_d   = ovf_q;
    has_f   = 1'b0;
    has_n   = 1'b0;
    n_kind  = TK_EOF;
    n_start = pos_q;
    n_len   = '0;
    cont    = 1'b1;
    nl      = (ichar_q == CH_CR) || (ichar_q == CH_LF);
    mine    = (ichar_q == CH_CR) ? PAIR_CR : PAIR_LF;
    prod    = {1'b0, val_q, 3'b000} + {3'b000, val_q, 1'b0}
            + (VALUE_BITS+4)'(ichar_q[3:0]);

    if (mode_q == M_HALT) begin
      // dead until reset
    end else if (ikind_q) begin
      has_f  = (mode_q == M_IDENT) || (mode_q == M_INT) || (mode_q == M_OP)
            || (mode_q == M_SLASH);
      has_n  = 1'b1;
      n_kind = TK_EOF;
      mode_d = M_IDLE;
      pair_d = PAIR_NONE;
    end else begin
      pos_d = pos_q + OFFSET_BITS'(1);
      case (mode_q)
        M_COMMENT: begin
          if (nl) mode_d = M_IDLE;
          else cont = 1'b0;
        end
        M_OP: begin
          if (ichar_q == "=") begin
            has_n   = 1'b1;
            n_kind  = op_kind(pend_q, 1'b1);
            n_start = start_q;
            n_len   = LEN_BITS'(2);
            mode_d  = M_IDLE;
            cont    = 1'b0;
          end else begin
            has_f  = 1'b1;
            mode_d = M_IDLE;
          end
        end
        M_SLASH: begin
          if (ichar_q == "/") begin
            mode_d = M_COMMENT;
            cont   = 1'b0;
          end else begin
            has_f  = 1'b1;
            mode_d = M_IDLE;
          end
        end
        M_IDENT: begin
          if (ichar_q inside {["a":"z"], ["A":"Z"], ["0":"9"], "_"}) begin
            for (int i = 0; i < KW_BYTES; i++) begin
              if (len_q == LEN_BITS'(i)) kw_d[8*i +: 8] = ichar_q;
            end
            if (len_q != LEN_MAX) len_d = len_q + LEN_BITS'(1);
            cont = 1'b0;
          end else begin
            has_f  = 1'b1;
            mode_d = M_IDLE;
          end
        end
        M_INT: begin
          if (ichar_q inside {["0":"9"]}) begin
            // value*10+digit past the top bits means saturation
            if (ovf_q || (prod[VALUE_BITS+3:VALUE_BITS] != 4'b0000)) begin
              val_d = '1;
              ovf_d = 1'b1;
            end else begin
              val_d = prod[VALUE_BITS-1:0];
            end
            if (len_q != LEN_MAX) len_d = len_q + LEN_BITS'(1);
            cont = 1'b0;
          end else begin
            has_f  = 1'b1;
            mode_d = M_IDLE;
          end
        end
        default: ;
      endcase

      if (cont) begin
        if (nl) begin
          // second half of crlf or lfcr closes the pair without a new line
          if (pair_q != PAIR_NONE && pair_q != mine) begin
            pair_d = PAIR_NONE;
          end else begin
            if (line_q != '1) line_d = line_q + LINE_BITS'(1);
            pair_d = mine;
          end
        end else begin
          pair_d = PAIR_NONE;
          if (ichar_q inside {" ", CH_TAB, CH_VT, CH_FF}) begin
            // whitespace
          end else if (ichar_q inside {["a":"z"], ["A":"Z"], "_"}) begin
            mode_d  = M_IDENT;
            start_d = pos_q;
            kw_d    = {{(8*KW_BYTES-8){1'b0}}, ichar_q};
            len_d   = LEN_BITS'(1);
          end else if (ichar_q inside {["0":"9"]}) begin
            mode_d  = M_INT;
            start_d = pos_q;
            val_d   = VALUE_BITS'(ichar_q[3:0]);
            ovf_d   = 1'b0;
            len_d   = LEN_BITS'(1);
          end else if (ichar_q inside {"<", ">", "=", "!"}) begin
            mode_d  = M_OP;
            start_d = pos_q;
            pend_d  = ichar_q;
          end else if (ichar_q == "/") begin
            mode_d  = M_SLASH;
            start_d = pos_q;
          end else if (op_kind(ichar_q, 1'b0) != TK_ERROR) begin
            has_n  = 1'b1;
            n_kind = op_kind(ichar_q, 1'b0);
            n_len  = LEN_BITS'(1);
          end else begin
            has_n  = 1'b1;
            n_kind = TK_ERROR;
            n_len  = LEN_BITS'(1);
            mode_d = M_HALT;
          end
        end
      end
    end
  end

  // the pending token as it stands before this beat
  always_comb begin
    f_len = len_q;
    f_val = '0;
    f_ovf = 1'b0;
    case (mode_q)
      M_IDENT: f_kind = ident_kind(kw_q, len_q);
      M_INT: begin
        f_kind = TK_INT;
        f_val  = val_q;
        f_ovf  = ovf_q;
      end
      M_OP: begin
        f_kind = op_kind(pend_q, 1'b0);
        f_len  = LEN_BITS'(1);
      end
      default: begin
        f_kind = TK_SLASH;
        f_len  = LEN_BITS'(1);
      end
    endcase
  end

  assign cnt   = {1'b0, has_f} + {1'b0, has_n};
  assign fire  = iv_q && (cnt <= room_i.free);
  assign f_tok = {f_kind, line_q, start_q, f_len, f_val, f_ovf, !has_n};
  assign n_tok = {n_kind, line_q, n_start, n_len, {VALUE_BITS{1'b0}}, 1'b0, 1'b1};

  assign tok0_o       = has_f ? f_tok : n_tok;
  assign tok1_o       = n_tok;
  assign push_o.count = fire ? cnt : 2'd0;
  assign byte_i.ready = !iv_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q    <= 1'b0;
      ikind_q <= 1'b0;
      ichar_q <= '0;
      mode_q  <= M_IDLE;
      pair_q  <= PAIR_NONE;
      pend_q  <= '0;
      kw_q    <= '0;
      len_q   <= '0;
      start_q <= '0;
      pos_q   <= '0;
      line_q  <= LINE_BITS'(1);
      val_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (byte_i.valid && byte_i.ready) begin
        iv_q    <= 1'b1;
        ikind_q <= byte_i.kind;
        ichar_q <= byte_i.char_byte;
      end else if (fire) begin
        iv_q <= 1'b0;
      end
      if (fire) begin
        mode_q  <= mode_d;
        pair_q  <= pair_d;
        pend_q  <= pend_d;
        kw_q    <= kw_d;
        len_q   <= len_d;
        start_q <= start_d;
        pos_q   <= pos_d;
        line_q  <= line_d;
        val_q   <= val_d;
        ovf_q   <= ovf_d;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cbt_obuf.sv -----
// cbt_obuf: two-slot result queue that takes up to two tokens a cycle
// depends on cbt_pkg
`default_nettype none

module cbt_obuf #(
  parameter int unsigned WIDTH = 8
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  cbt_pkg::cbt_push_t  push_i,
  input  logic [WIDTH-1:0]    tok0_i,
  input  logic [WIDTH-1:0]    tok1_i,
  output cbt_pkg::cbt_room_t  room_o,
  output logic                valid_o,
  input  wire                 ready_i,
  output logic [WIDTH-1:0]    data_o
);
  import cbt_pkg::*;

  logic             v0_q, v1_q;
  logic [WIDTH-1:0] s0_q, s1_q, s0_d, s1_d, rem0;
  logic             pop;
  logic [1:0]       rem_cnt, total;

  assign pop     = v0_q && ready_i;
  assign rem_cnt = {1'b0, v0_q} + {1'b0, v1_q} - {1'b0, pop};
  assign rem0    = pop ? s1_q : s0_q;
  assign total   = rem_cnt + push_i.count;
  assign room_o.free = 2'd2 - rem_cnt;

  always_comb begin
    s0_d = (rem_cnt != 2'd0) ? rem0 : tok0_i;
    case (rem_cnt)
      2'd2:    s1_d = s1_q;
      2'd1:    s1_d = tok0_i;
      default: s1_d = tok1_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= (total != 2'd0);
      v1_q <= (total == 2'd2);
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

  assign valid_o = v0_q;
  assign data_o  = s0_q;

endmodule

`default_nettype wire

// ----- test/c_like_byte_tokenizer_tb.sv -----
// c_like_byte_tokenizer_tb: self-checking bench for the c-like byte tokenizer
// feeds byte and end beats, predicts every token in step and compares them in order
// depends on cbt_pkg, cbt_in_if, cbt_out_if and c_like_byte_tokenizer
`timescale 1ns / 100ps

module c_like_byte_tokenizer_tb;
  import cbt_pkg::*;

  localparam int unsigned LB = LINE_BITS_DEF;
  localparam int unsigned OB = OFFSET_BITS_DEF;
  localparam int unsigned VB = VALUE_BITS_DEF;

  localparam bit KIND_BYTE = 1'b0;
  localparam bit KIND_END  = 1'b1;

  localparam logic [15:0]   LEN_SAT  = 16'hFFFF;
  localparam logic [VB-1:0] VALUE_SAT = {VB{1'b1}};
  localparam logic [LB-1:0] LINE_SAT  = {LB{1'b1}};

  localparam int RANDOM_BYTES = 550;
  localparam int HOLD_AT      = 300;     // input beats taken before the long sink stall
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 10;

  // scanner modes of the predictor
  typedef enum logic [2:0] {
    SM_IDLE, SM_IDENT, SM_INT, SM_OP, SM_SLASH, SM_COMMENT, SM_HALT
  } scan_mode_e;

  // which newline byte could pair with the next one
  typedef enum logic [1:0] { NL_NONE, NL_CR, NL_LF } nl_pair_e;

  typedef struct {
    bit         is_end;
    logic [7:0] ch;
  } src_beat_t;

  typedef struct {
    tok_kind_e      kind;
    logic [LB-1:0]  line;
    logic [OB-1:0]  start;
    logic [15:0]    len;
    logic [VB-1:0]  value;
    logic           ovf;
    logic           last;
  } token_t;

  logic clk_i;
  logic rst_ni;

  cbt_in_if  byte_ch ();
  cbt_out_if #(.LINE_BITS(LB), .OFFSET_BITS(OB), .VALUE_BITS(VB)) tok_ch ();

  c_like_byte_tokenizer #(
    .LINE_BITS  (LB),
    .OFFSET_BITS(OB),
    .VALUE_BITS (VB)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_ch),
    .token_o(tok_ch)
  );

  // ---------------------------------------------------------------------------
  // token predictor: its own copy of the scanner state
  // ---------------------------------------------------------------------------
  scan_mode_e    mode;
  nl_pair_e      nl_pair;
  logic [7:0]    pend_op;
  logic [7:0]    word_head [KW_BYTES];   // first bytes of the identifier being built
  logic [15:0]   cur_len;
  logic [OB-1:0] tok_start;
  logic [OB-1:0] byte_pos;
  logic [LB-1:0] line_cnt;
  logic [VB-1:0] acc;
  logic          acc_ovf;

  token_t fresh[$];        // tokens made by the beat being predicted
  token_t tokens_due[$];   // tokens still to arrive, oldest first
  src_beat_t src_beats[$]; // beats not yet offered to the block
  int bad_count;
  int calm_at;             // queue depth at or below which nobody idles

  function automatic void lex_reset();
    mode      = SM_IDLE;
    nl_pair   = NL_NONE;
    pend_op   = '0;
    cur_len   = '0;
    tok_start = '0;
    byte_pos  = '0;
    line_cnt  = LB'(1);
    acc       = '0;
    acc_ovf   = 1'b0;
    foreach (word_head[i]) word_head[i] = '0;
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic tok_kind_e op_of(logic [7:0] c, bit with_eq);
    case (c)
      ";": return TK_SEMI;
      "(": return TK_LPAREN;
      ")": return TK_RPAREN;
      "{": return TK_LBRACE;
      "}": return TK_RBRACE;
      "-": return TK_MINUS;
      "+": return TK_PLUS;
      "*": return TK_STAR;
      "/": return TK_SLASH;
      "%": return TK_PERCENT;
      "=": return with_eq ? TK_EQ : TK_ASSIGN;
      "<": return with_eq ? TK_LE : TK_LT;
      ">": return with_eq ? TK_GE : TK_GT;
      "!": return with_eq ? TK_NE : TK_NOT;
      default: return TK_ERROR;
    endcase
  endfunction

  // identifier text equals s: same length and same leading bytes
  function automatic bit head_is(string s);
    if (cur_len != 16'(s.len())) return 1'b0;
    for (int i = 0; i < s.len(); i++)
      if (word_head[i] != s[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic tok_kind_e word_kind();
    if (head_is("else"))  return TK_ELSE;
    if (head_is("false")) return TK_FALSE;
    if (head_is("if"))    return TK_IF;
    if (head_is("true"))  return TK_TRUE;
    if (head_is("while")) return TK_WHILE;
    return TK_IDENT;
  endfunction

  function automatic void put_tok(tok_kind_e k, logic [OB-1:0] st, logic [15:0] ln,
                                  logic [VB-1:0] v, logic o);
    token_t t;
    t.kind  = k;
    t.line  = line_cnt;
    t.start = st;
    t.len   = ln;
    t.value = v;
    t.ovf   = o;
    t.last  = 1'b0;
    fresh.push_back(t);
  endfunction

  function automatic void flush_pending();
    case (mode)
      SM_IDENT: put_tok(word_kind(), tok_start, cur_len, '0, 1'b0);
      SM_INT:   put_tok(TK_INT, tok_start, cur_len, acc, acc_ovf);
      SM_OP:    put_tok(op_of(pend_op, 1'b0), tok_start, 16'd1, '0, 1'b0);
      SM_SLASH: put_tok(TK_SLASH, tok_start, 16'd1, '0, 1'b0);
      default: ;
    endcase
    mode = SM_IDLE;
  endfunction

  function automatic void start_tok(scan_mode_e m, logic [OB-1:0] pos);
    mode      = m;
    tok_start = pos;
    cur_len   = '0;
    acc       = '0;
    acc_ovf   = 1'b0;
    foreach (word_head[i]) word_head[i] = '0;
  endfunction

  function automatic void grow_word(logic [7:0] c);
    if (cur_len < 16'(KW_BYTES)) word_head[cur_len] = c;
    if (cur_len != LEN_SAT) cur_len++;
  endfunction

  // decimal accumulate, pinned at the all-ones value once it would overflow
  function automatic void grow_value(logic [7:0] c);
    logic [VB+3:0] wide;
    wide = (VB+4)'(acc) * 10 + (VB+4)'(c - "0");
    if (acc_ovf || wide > (VB+4)'(VALUE_SAT)) begin
      acc     = VALUE_SAT;
      acc_ovf = 1'b1;
    end else begin
      acc = wide[VB-1:0];
    end
    if (cur_len != LEN_SAT) cur_len++;
  endfunction

  function automatic void lex_byte(logic [7:0] c, logic [OB-1:0] pos);
    bit nl;
    nl_pair_e mine;
    tok_kind_e k;
    nl = (c == CH_CR) || (c == CH_LF);

    // first let the pending token decide whether this byte continues it
    case (mode)
      SM_COMMENT: begin
        if (!nl) return;
        mode = SM_IDLE;
      end
      SM_OP: begin
        if (c == "=") begin
          put_tok(op_of(pend_op, 1'b1), tok_start, 16'd2, '0, 1'b0);
          mode = SM_IDLE;
          return;
        end
        flush_pending();
      end
      SM_SLASH: begin
        if (c == "/") begin
          mode = SM_COMMENT;
          return;
        end
        flush_pending();
      end
      SM_IDENT: begin
        if (is_letter(c) || is_digit(c) || c == "_") begin
          grow_word(c);
          return;
        end
        flush_pending();
      end
      SM_INT: begin
        if (is_digit(c)) begin
          grow_value(c);
          return;
        end
        flush_pending();
      end
      default: ;
    endcase

    // a cr/lf pair of different bytes counts once, a repeat counts again
    if (nl) begin
      mine = (c == CH_CR) ? NL_CR : NL_LF;
      if (nl_pair != NL_NONE && nl_pair != mine) begin
        nl_pair = NL_NONE;
      end else begin
        if (line_cnt != LINE_SAT) line_cnt++;
        nl_pair = mine;
      end
      return;
    end
    nl_pair = NL_NONE;

    if (c == " " || c == CH_TAB || c == CH_VT || c == CH_FF) return;
    if (is_letter(c) || c == "_") begin
      start_tok(SM_IDENT, pos);
      grow_word(c);
      return;
    end
    if (is_digit(c)) begin
      start_tok(SM_INT, pos);
      grow_value(c);
      return;
    end
    if (c == "<" || c == ">" || c == "=" || c == "!") begin
      start_tok(SM_OP, pos);
      pend_op = c;
      return;
    end
    if (c == "/") begin
      start_tok(SM_SLASH, pos);
      return;
    end
    k = op_of(c, 1'b0);
    put_tok(k, pos, 16'd1, '0, 1'b0);
    // unknown byte: error token, then the scanner stays dead
    if (k == TK_ERROR) mode = SM_HALT;
  endfunction

  // one accepted beat: work out its tokens and queue them
  function automatic void lex_beat(bit is_end, logic [7:0] c);
    logic [OB-1:0] pos;
    fresh.delete();
    if (mode == SM_HALT) return;
    if (is_end) begin
      flush_pending();
      put_tok(TK_EOF, byte_pos, 16'd0, '0, 1'b0);
      mode    = SM_IDLE;
      nl_pair = NL_NONE;
    end else begin
      pos      = byte_pos;
      byte_pos = byte_pos + 1'b1;
      lex_byte(c, pos);
    end
    if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
    foreach (fresh[i]) tokens_due.push_back(fresh[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  function automatic void push_byte(logic [7:0] c);
    src_beat_t b;
    b.is_end = KIND_BYTE;
    b.ch     = c;
    src_beats.push_back(b);
  endfunction

  // end beat; its byte lane carries junk on purpose
  function automatic void push_end();
    src_beat_t b;
    b.is_end = KIND_END;
    b.ch     = 8'($urandom_range(0, 255));
    src_beats.push_back(b);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [7:0] word_char(bit first);
    int r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  function automatic void push_newline();
    case ($urandom_range(0, 4))
      0: push_byte(CH_CR);
      1: push_byte(CH_LF);
      2: begin push_byte(CH_CR); push_byte(CH_LF); end
      3: begin push_byte(CH_LF); push_byte(CH_CR); end
      default: begin push_byte(CH_CR); push_byte(CH_CR); end
    endcase
  endfunction

  function automatic void push_blank();
    case ($urandom_range(0, 3))
      0: push_byte(" ");
      1: push_byte(CH_TAB);
      2: push_byte(CH_VT);
      default: push_byte(CH_FF);
    endcase
  endfunction

  // one random lexical fragment, mostly well-formed; neighbors may glue together
  function automatic void push_fragment();
    string kw_list [5] = '{"else", "false", "if", "true", "while"};
    string op_chars = ";(){}=-+*/%<>!";
    logic [7:0] c;
    int n;
    case ($urandom_range(0, 15))
      0, 1, 2: begin
        n = $urandom_range(1, 8);
        push_byte(word_char(1'b1));
        for (int i = 1; i < n; i++) push_byte(word_char(1'b0));
      end
      3, 4: begin
        push_text(kw_list[$urandom_range(0, 4)]);
        // sometimes a suffix turns the keyword back into a plain identifier
        if ($urandom_range(0, 3) == 0) push_byte(word_char(1'b0));
      end
      5, 6: begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 5);
        for (int i = 0; i < n; i++) push_byte(8'("0" + $urandom_range(0, 9)));
      end
      7, 8, 9: begin
        push_byte(op_chars[$urandom_range(0, op_chars.len() - 1)]);
        if ($urandom_range(0, 2) == 0) push_byte("=");
      end
      10, 11: push_blank();
      12: push_newline();
      13: begin
        // comment with arbitrary bytes, closed by a newline or by end
        push_text("//");
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
          push_byte(c);
        end
        if ($urandom_range(0, 3) == 0) push_end();
        else push_newline();
      end
      14: push_byte("/");
      default: begin
        if ($urandom_range(0, 1) == 0) push_end();
        else push_blank();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    byte_ch.valid     = 1'b0;
    byte_ch.kind      = KIND_BYTE;
    byte_ch.char_byte = '0;
    tok_ch.ready      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // idling: stretches with and without random bubbles, none near the end
  // ---------------------------------------------------------------------------
  logic idle_on;
  int   stretch_left;

  function automatic bit may_idle();
    return idle_on && (src_beats.size() > calm_at);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_on      <= 1'b1;
      stretch_left <= 64;
    end else if (stretch_left == 0) begin
      idle_on      <= ~idle_on;
      stretch_left <= $urandom_range(20, 120);
    end else begin
      stretch_left <= stretch_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: offers queued beats, predicts each one as it is taken
  // ---------------------------------------------------------------------------
  src_beat_t offer;
  int        gap_left;
  int        beats_in;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_ch.valid     <= 1'b0;
      byte_ch.kind      <= KIND_BYTE;
      byte_ch.char_byte <= '0;
      gap_left          <= 0;
      beats_in          <= 0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        lex_beat(byte_ch.kind, byte_ch.char_byte);
        beats_in <= beats_in + 1;
      end
      // the slot is free when nothing is offered or the offer was just taken
      if (!byte_ch.valid || byte_ch.ready) begin
        if (gap_left > 0) begin
          byte_ch.valid <= 1'b0;
          gap_left      <= gap_left - 1;
        end else if (src_beats.size() > 0 && may_idle() && $urandom_range(0, 5) == 0) begin
          byte_ch.valid <= 1'b0;
          gap_left      <= $urandom_range(0, 3);
        end else if (src_beats.size() > 0) begin
          offer = src_beats.pop_front();
          byte_ch.valid     <= 1'b1;
          byte_ch.kind      <= offer.is_end;
          byte_ch.char_byte <= offer.ch;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sink: one long hold-off so the result queue fills and the input backs up
  // ---------------------------------------------------------------------------
  int hold_left;
  bit hold_done;
  int stall_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && beats_in >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (hold_left > 0) begin
      tok_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      tok_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (may_idle() && $urandom_range(0, 4) == 0) begin
      tok_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 3);
    end else begin
      tok_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every token beat against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void check_token();
    token_t want;
    if (tokens_due.size() == 0) begin
      bad_count++;
      if (bad_count <= 10)
        $display("extra: kind=%0d line=%0d start=%0d len=%0d val=%0d ovf=%0b last=%0b",
                 tok_ch.token_kind, tok_ch.line_number, tok_ch.start_offset,
                 tok_ch.token_length, tok_ch.int_value, tok_ch.int_overflow,
                 tok_ch.last_of_run);
      return;
    end
    want = tokens_due.pop_front();
    if (tok_ch.token_kind !== want.kind || tok_ch.line_number !== want.line ||
        tok_ch.start_offset !== want.start || tok_ch.token_length !== want.len ||
        tok_ch.int_value !== want.value || tok_ch.int_overflow !== want.ovf ||
        tok_ch.last_of_run !== want.last) begin
      bad_count++;
      if (bad_count <= 10) begin
        $display("want: kind=%0d line=%0d start=%0d len=%0d val=%0d ovf=%0b last=%0b",
                 want.kind, want.line, want.start, want.len, want.value, want.ovf,
                 want.last);
        $display("got:  kind=%0d line=%0d start=%0d len=%0d val=%0d ovf=%0b last=%0b",
                 tok_ch.token_kind, tok_ch.line_number, tok_ch.start_offset,
                 tok_ch.token_length, tok_ch.int_value, tok_ch.int_overflow,
                 tok_ch.last_of_run);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && tok_ch.valid && tok_ch.ready) check_token();
  end

  // ---------------------------------------------------------------------------
  // stimulus plan and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int n0;
    bad_count = 0;
    calm_at   = 0;
    lex_reset();

    // every operator, with the two-byte forms right after their prefixes
    push_text(";(){}=-+*%<<=>>===!=!/");
    push_end();
    // keywords, both newline pairs, a doubled newline, the largest and an
    // overflowing integer, a comment with high bytes, then end inside the comment
    push_text("while else");
    push_byte(CH_CR); push_byte(CH_LF);
    push_text("false");
    push_byte(CH_LF); push_byte(CH_CR);
    push_text("true");
    push_byte(CH_TAB);
    push_text("if");
    push_byte(CH_LF); push_byte(CH_LF);
    push_text("4294967295");
    push_byte(CH_VT);
    push_text("4294967296 00_z9");
    push_byte(CH_FF);
    push_text("a//x");
    push_byte(8'hFF); push_byte(8'h00); push_byte(8'h80);
    push_end();

    // random fragments
    n0 = src_beats.size();
    while (src_beats.size() - n0 < RANDOM_BYTES) push_fragment();

    // quiet tail: random fragments, then an unknown byte that flushes a pending
    // identifier, then beats that the halted block must swallow silently
    n0 = src_beats.size();
    while (src_beats.size() - n0 < 100) push_fragment();
    push_byte(CH_LF);
    push_text("q@ab");
    push_end();
    push_text("1;");
    push_end();
    calm_at = src_beats.size() - n0;

    // wait for the last beat to go in and the last token to come out
    @(negedge clk_i);
    while (src_beats.size() != 0 || byte_ch.valid) @(negedge clk_i);
    while (tokens_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (tokens_due.size() != 0) begin
      bad_count += tokens_due.size();
      $display("%0d predicted tokens never arrived", tokens_due.size());
    end
    if (bad_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run (about 100 ms)
  initial begin
    #100_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
